// ===== rtl/fpa_pkg.sv =====
// Shared types and opcode constants for the fixed-point ALU.
// No dependencies. The ALU modules import this package.
package fpa_pkg;

  localparam int unsigned CMD_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_ADD  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SUB  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MUL  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DIV  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_GT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_LT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_GE   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LE   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_EQ   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_NE   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_MIN  = 4'd10;
  localparam logic [CMD_W-1:0] CMD_MAX  = 4'd11;
  localparam logic [CMD_W-1:0] CMD_INC  = 4'd12;
  localparam logic [CMD_W-1:0] CMD_DEC  = 4'd13;
  localparam logic [CMD_W-1:0] CMD_I2F  = 4'd14;
  localparam logic [CMD_W-1:0] CMD_F2I  = 4'd15;

  // Side band that rides along the divider stages
  typedef struct packed {
    logic [DATA_W-1:0] val;    // result of any non-divide operation
    logic              flag;   // comparison outcome
    logic              is_div; // replace val by the quotient at the end
    logic              neg;    // quotient sign
    logic              dzero;  // divisor was zero
  } fpa_side_t;

endpackage

// ===== rtl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side band.
// Depends on fpa_pkg.
module fpa_div import fpa_pkg::*; #(
  parameter int unsigned DW = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  fpa_side_t         in_side,
  input  logic [DW-1:0]     in_num,
  input  logic [DATA_W-1:0] in_den,
  output logic              out_vld,
  output fpa_side_t         out_side,
  output logic [DATA_W-1:0] out_quo
);

  wire              vld_r  [DW+1];
  wire fpa_side_t   side_r [DW+1];
  wire [DW-1:0]     num_r  [DW+1];
  wire [DATA_W-1:0] den_r  [DW+1];
  wire [DATA_W-1:0] rem_r  [DW+1];

  assign vld_r[0]  = in_vld;
  assign side_r[0] = in_side;
  assign num_r[0]  = in_num;
  assign den_r[0]  = in_den;
  assign rem_r[0]  = '0;

  // one stage per quotient bit; quotient bits shift in behind the dividend
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W:0]   diff;
    logic              vld_q;
    fpa_side_t         side_q;
    logic [DW-1:0]     num_q;
    logic [DATA_W-1:0] den_q;
    logic [DATA_W-1:0] rem_q;

    assign trial = {rem_r[k], num_r[k][DW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};
    assign diff  = trial - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q <= side_r[k];
        den_q  <= den_r[k];
        num_q  <= {num_r[k][DW-2:0], ge};
        rem_q  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      end
    end

    assign vld_r[k+1]  = vld_q;
    assign side_r[k+1] = side_q;
    assign num_r[k+1]  = num_q;
    assign den_r[k+1]  = den_q;
    assign rem_r[k+1]  = rem_q;
  end

  assign out_vld  = vld_r[DW];
  assign out_side = side_r[DW];
  assign out_quo  = num_r[DW][DATA_W-1:0];

endmodule

// ===== rtl/fixed_point_alu_top.sv =====
// Signed Q24.8 data with the default FRAC_BITS; one beat per cycle while the output is not stalled.
// The divider takes one stage per quotient bit and sets the depth; every
// operation goes through the same stages so results leave in order.
// A stalled output freezes the whole pipeline; in_stall mirrors it.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Depends on fpa_pkg and fpa_div.
module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     flag
);

  localparam int unsigned DW = DATA_W + FRAC_BITS;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: input beat register
  logic                     s1_vld;
  logic [CMD_W-1:0]         s1_cmd;
  logic signed [DATA_W-1:0] s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd <= cmd;
      s1_a   <= operand_a;
      s1_b   <= operand_b;
    end
  end

  // stage 2: simple ops, product, divider operand prep
  logic              lt, gt, eq;
  logic [DATA_W-1:0] simple_val;
  logic              simple_flag;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign lt = s1_a < s1_b;
  assign gt = s1_a > s1_b;
  assign eq = s1_a == s1_b;
  assign abs_a = s1_a[DATA_W-1] ? DATA_W'(-s1_a) : DATA_W'(s1_a);
  assign abs_b = s1_b[DATA_W-1] ? DATA_W'(-s1_b) : DATA_W'(s1_b);

  always_comb begin
    simple_val  = '0;
    simple_flag = 1'b0;
    unique case (s1_cmd)
      CMD_ADD: simple_val = DATA_W'(s1_a + s1_b);
      CMD_SUB: simple_val = DATA_W'(s1_a - s1_b);
      CMD_MUL: simple_val = '0;
      CMD_DIV: simple_val = '0;
      CMD_GT:  simple_flag = gt;
      CMD_LT:  simple_flag = lt;
      CMD_GE:  simple_flag = !lt;
      CMD_LE:  simple_flag = !gt;
      CMD_EQ:  simple_flag = eq;
      CMD_NE:  simple_flag = !eq;
      CMD_MIN: simple_val = lt ? s1_a : s1_b;
      CMD_MAX: simple_val = gt ? s1_a : s1_b;
      CMD_INC: simple_val = DATA_W'(s1_a + 1);
      CMD_DEC: simple_val = DATA_W'(s1_a - 1);
      CMD_I2F: simple_val = DATA_W'(s1_a <<< FRAC_BITS);
      CMD_F2I: simple_val = DATA_W'(s1_a >>> FRAC_BITS);
      default: simple_val = '0;
    endcase
  end

  logic                       s2_vld;
  fpa_side_t                  s2_side;
  logic                       s2_is_mul;
  logic signed [2*DATA_W-1:0] s2_prod;
  logic [DW-1:0]              s2_num;
  logic [DATA_W-1:0]          s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.val    <= simple_val;
      s2_side.flag   <= simple_flag;
      s2_side.is_div <= s1_cmd == CMD_DIV;
      s2_side.neg    <= s1_a[DATA_W-1] ^ s1_b[DATA_W-1];
      s2_side.dzero  <= s1_b == '0;
      s2_is_mul      <= s1_cmd == CMD_MUL;
      s2_prod        <= s1_a * s1_b;
      s2_num         <= DW'(abs_a) << FRAC_BITS;
      s2_den         <= abs_b;
    end
  end

  // stage 3 onward: scaled product merged, then divider stages
  fpa_side_t         div_in_side;
  logic [DATA_W-1:0] prod_shifted;

  assign prod_shifted = DATA_W'(s2_prod >>> FRAC_BITS);

  always_comb begin
    div_in_side = s2_side;
    if (s2_is_mul) begin
      div_in_side.val = prod_shifted;
    end
  end

  logic              d_vld;
  fpa_side_t         d_side;
  logic [DATA_W-1:0] d_quo;

  fpa_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s2_vld),
    .in_side  (div_in_side),
    .in_num   (s2_num),
    .in_den   (s2_den),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_quo  (d_quo)
  );

  // output register: signed quotient select, zero on a zero divisor, else the side-band value
  logic [DATA_W-1:0] final_val;

  always_comb begin
    final_val = d_side.val;
    if (d_side.is_div) begin
      if (d_side.dzero) begin
        final_val = '0;
      end else begin
        final_val = d_side.neg ? DATA_W'(-d_quo) : d_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= final_val;
      flag  <= d_side.flag;
    end
  end

  // checks
  a_flag_zero_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag |-> value == '0)
    else $error("comparison beat with nonzero value");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    en && d_vld && d_side.is_div && d_side.dzero |=> value == '0 && !flag)
    else $error("divide by zero gave nonzero result");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(d_vld) && $stable(s2_vld) && $stable(s1_vld))
    else $error("pipeline moved while output stalled");

endmodule

// ===== bench/tb_fixed_point_alu_top.sv =====
// Self-checking bench for fixed_point_alu_top: directed corner beats, then random beats.
// Depends on fpa_pkg and the ALU RTL; results are predicted in-bench and scoreboarded.
`timescale 1ns / 100ps

module tb_fixed_point_alu_top;
  import fpa_pkg::*;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned LATENCY = 3 + 32 + FRAC_BITS;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
  } alu_result_t;

  // Scoreboard: predicts each accepted beat and checks results in order
  class alu_scoreboard;
    alu_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned op_seen[16];

    function alu_result_t compute(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] a,
                                  logic signed [DATA_W-1:0] b);
      alu_result_t r;
      logic signed [63:0] wide;
      logic signed [63:0] num;
      r.value = '0;
      r.flag = 1'b0;
      case (op)
        CMD_ADD: r.value = a + b;
        CMD_SUB: r.value = a - b;
        CMD_MUL: begin
          wide = 64'(a) * 64'(b);
          wide = wide >>> FRAC_BITS;
          r.value = wide[DATA_W-1:0];
        end
        CMD_DIV: begin
          if (b != 0) begin
            num = 64'(a) <<< FRAC_BITS;
            wide = num / 64'(b);  // SV signed division truncates toward zero
            r.value = wide[DATA_W-1:0];
          end
        end
        CMD_GT: r.flag = a > b;
        CMD_LT: r.flag = a < b;
        CMD_GE: r.flag = a >= b;
        CMD_LE: r.flag = a <= b;
        CMD_EQ: r.flag = a == b;
        CMD_NE: r.flag = a != b;
        CMD_MIN: r.value = (a < b) ? a : b;
        CMD_MAX: r.value = (a > b) ? a : b;
        CMD_INC: r.value = a + 1;
        CMD_DEC: r.value = a - 1;
        CMD_I2F: r.value = a <<< FRAC_BITS;
        default: r.value = a >>> FRAC_BITS;
      endcase
      return r;
    endfunction

    function void note_input(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] a,
                             logic signed [DATA_W-1:0] b);
      pending.push_back(compute(op, a, b));
      op_seen[op]++;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [DATA_W-1:0] v, logic f);
      alu_result_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat value=%h flag=%b", v, f));
        return;
      end
      want = pending.pop_front();
      if (v !== want.value)
        report($sformatf("value got %h want %h", v, want.value));
      if (f !== want.flag)
        report($sformatf("flag got %b want %b", f, want.flag));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] cmd;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] value;
  logic flag;

  alu_scoreboard sb;
  bit quiet_mode;  // long stretch with no idling on either side
  bit stim_done;

  fixed_point_alu_top #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .flag(flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random 32-bit operand biased toward corner values
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return 32'(int'($urandom_range(0, 1024)) - 512);
      4: return 32'(int'($urandom_range(0, 65535)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  // Drive one beat and hold it until accepted
  task automatic send_beat(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] a,
                           logic signed [DATA_W-1:0] b);
    while (!quiet_mode && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, a, b);
  endtask

  // Output side: random stall, check on accept
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(value, flag);
      out_stall <= !quiet_mode && ($urandom_range(0, 99) < 16);
    end
  end

  // Stimulus
  initial begin
    logic [CMD_W-1:0] op;
    int unsigned waited;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    operand_a = '0;
    operand_b = '0;
    quiet_mode = 1'b0;
    stim_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every op on extremes, zero divisor, overflow wrap
    for (int i = 0; i < 16; i++)
      send_beat(CMD_W'(i), 32'sh7fff_ffff, 32'sh8000_0000);
    send_beat(CMD_DIV, 32'sh0000_1234, 32'sd0);
    send_beat(CMD_DIV, 32'sh8000_0000, 32'sd1);
    send_beat(CMD_DIV, -32'sd769, 32'sd512);
    send_beat(CMD_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_beat(CMD_MUL, -32'sd1, 32'sd1);
    send_beat(CMD_F2I, -32'sd1, 32'sd0);
    send_beat(CMD_EQ, 32'sd5, 32'sd5);
    send_beat(CMD_MIN, 32'sd5, 32'sd5);
    send_beat(CMD_I2F, 32'sh0080_0000, -32'sd1);

    // Random, with a no-idle stretch in the middle
    for (int n = 0; n < 700; n++) begin
      quiet_mode = (n >= 300 && n < 420);
      op = CMD_W'($urandom_range(0, 15));
      send_beat(op, pick_operand(), pick_operand());
    end
    quiet_mode = 1'b0;
    in_valid <= 1'b0;

    // Drain
    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1'b1;
    $display("Covered %0d result beats over all 16 opcodes (div seen %0d, mul seen %0d).",
             sb.checked, sb.op_seen[CMD_DIV], sb.op_seen[CMD_MUL]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fixed_point_alu_top regression: pass");
    end else begin
      $display("fixed_point_alu_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    if (!stim_done) begin
      $display("fixed_point_alu_top regression: fail");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_top.sv
bench/tb_fixed_point_alu_top.sv
